// ----- hdl/wbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Whitespace-blind pattern matcher package
// Shared constants, register codes and the result beat type.
// ----------------------------------------------------------------------------
package wbpm_pkg;

  localparam int DATA_W          = 8;
  localparam int OUT_W           = 16;
  localparam int PAT_BYTES       = 8;
  localparam int PAT_W           = PAT_BYTES * DATA_W;
  localparam int LEN_W           = 4;
  localparam int ADDR_W          = 4;
  localparam int PDATA_W         = 64;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int POS_WIDTH_DEF   = 16;

  localparam logic [DATA_W-1:0] CHR_NL      = 8'h0A;
  localparam logic [DATA_W-1:0] CHR_TAB     = 8'h09;
  localparam logic [DATA_W-1:0] CHR_SPACE   = 8'h20;
  localparam logic [DATA_W-1:0] CHR_UPPER_A = 8'h41;
  localparam logic [DATA_W-1:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [DATA_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [OUT_W-1:0]  OUT_MAX     = 16'hFFFF;

  // Register index, taken from the 8-byte aligned address.
  typedef enum logic {
    REG_PATTERN_CHARS  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             match_found;
    logic [OUT_W-1:0] match_row;
    logic [OUT_W-1:0] match_col;
    logic [OUT_W-1:0] match_total;
  } res_t;

endpackage

// ----- hdl/wbpm_cfg.sv -----
// ----------------------------------------------------------------------------
// Whitespace-blind pattern matcher configuration registers
// APB-style write and read of the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module wbpm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wbpm_pkg::PDATA_W-1:0] pwdata,
  output logic [wbpm_pkg::PDATA_W-1:0] prdata,
  output logic [wbpm_pkg::PAT_W-1:0]   pattern_chars,
  output logic [wbpm_pkg::LEN_W-1:0]   pattern_length
);
  import wbpm_pkg::*;

  logic [PAT_W-1:0] pattern_chars_r;
  logic [LEN_W-1:0] pattern_length_r;
  reg_idx_t         reg_idx;
  logic             wr_en;

  // Byte-lane bits of the address are ignored.
  assign reg_idx = reg_idx_t'(paddr[3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_chars_r  <= '0;
      pattern_length_r <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_CHARS:  pattern_chars_r  <= pwdata[PAT_W-1:0];
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_CHARS:  prdata = PDATA_W'(pattern_chars_r);
      REG_PATTERN_LENGTH: prdata = PDATA_W'(pattern_length_r);
      default:            prdata = '0;
    endcase
  end

  assign pattern_chars  = pattern_chars_r;
  assign pattern_length = pattern_length_r;

endmodule

// ----- hdl/wbpm_core.sv -----
// ----------------------------------------------------------------------------
// Whitespace-blind pattern matcher core
// Character window, position tracking, pattern compare and match counter.
// ----------------------------------------------------------------------------
module wbpm_core #(
  parameter int MAX_PATTERN = wbpm_pkg::MAX_PATTERN_DEF,
  parameter int POS_WIDTH   = wbpm_pkg::POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [wbpm_pkg::DATA_W-1:0] data_byte,
  input  logic                        start_of_file,
  input  logic [wbpm_pkg::PAT_W-1:0]  pattern_chars,
  input  logic [wbpm_pkg::LEN_W-1:0]  pattern_length,
  output wbpm_pkg::res_t              res
);
  import wbpm_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int EXT_W  = (POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W;

  // Window entry 0 is the newest kept character.
  logic [DATA_W-1:0]    win_chr_r [MAX_PATTERN];
  logic [POS_WIDTH-1:0] win_row_r [MAX_PATTERN];
  logic [POS_WIDTH-1:0] win_col_r [MAX_PATTERN];
  logic [DATA_W-1:0]    win_chr_nxt [MAX_PATTERN];
  logic [POS_WIDTH-1:0] win_row_nxt [MAX_PATTERN];
  logic [POS_WIDTH-1:0] win_col_nxt [MAX_PATTERN];

  logic [FILL_W-1:0]    fill_r, fill_nxt, fill_base;
  logic [POS_WIDTH-1:0] row_r, row_nxt, row_base;
  logic [POS_WIDTH-1:0] col_r, col_nxt, col_base;
  logic [OUT_W-1:0]     cnt_r, cnt_nxt, cnt_base;

  logic [DATA_W-1:0]    pat_b [MAX_PATTERN];
  logic [FILL_W-1:0]    len_eff;
  logic [IDX_W-1:0]     pidx;
  logic [IDX_W-1:0]     first_idx;
  logic                 is_nl, is_blank, keep, hit;
  logic [DATA_W-1:0]    ch;
  logic [EXT_W-1:0]     row_ext, col_ext;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_b[j] = pattern_chars[j*DATA_W +: DATA_W];
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = FILL_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = FILL_W'(MAX_PATTERN);
    end else begin
      len_eff = FILL_W'(pattern_length);
    end
  end

  always_comb begin
    fill_base = start_of_file ? '0 : fill_r;
    row_base  = start_of_file ? POS_WIDTH'(1) : row_r;
    col_base  = start_of_file ? POS_WIDTH'(1) : col_r;
    cnt_base  = start_of_file ? '0 : cnt_r;

    is_nl    = (data_byte == CHR_NL);
    is_blank = (data_byte == CHR_TAB) || (data_byte == CHR_SPACE);
    keep     = !is_nl && !is_blank;

    if (data_byte >= CHR_UPPER_A && data_byte <= CHR_UPPER_Z) begin
      ch = data_byte + CASE_OFFSET;
    end else begin
      ch = data_byte;
    end

    win_chr_nxt[0] = ch;
    win_row_nxt[0] = row_base;
    win_col_nxt[0] = col_base;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_chr_nxt[j] = win_chr_r[j-1];
      win_row_nxt[j] = win_row_r[j-1];
      win_col_nxt[j] = win_col_r[j-1];
    end

    if (keep && fill_base != FILL_W'(MAX_PATTERN)) begin
      fill_nxt = fill_base + FILL_W'(1);
    end else begin
      fill_nxt = fill_base;
    end

    // Pattern byte k pairs with window entry len-1-k; entries past the
    // pattern length take no part.
    hit  = keep && (fill_nxt >= len_eff);
    pidx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = IDX_W'(len_eff - FILL_W'(1) - FILL_W'(j));
      if (FILL_W'(j) < len_eff && win_chr_nxt[j] != pat_b[pidx]) begin
        hit = 1'b0;
      end
    end

    first_idx = IDX_W'(len_eff - FILL_W'(1));
    row_ext   = EXT_W'(win_row_nxt[first_idx]);
    col_ext   = EXT_W'(win_col_nxt[first_idx]);

    if (hit && cnt_base != OUT_MAX) begin
      cnt_nxt = cnt_base + OUT_W'(1);
    end else begin
      cnt_nxt = cnt_base;
    end

    if (is_nl) begin
      row_nxt = (row_base == '1) ? row_base : row_base + POS_WIDTH'(1);
      col_nxt = POS_WIDTH'(1);
    end else begin
      row_nxt = row_base;
      col_nxt = (col_base == '1) ? col_base : col_base + POS_WIDTH'(1);
    end

    res.match_found = hit;
    res.match_row   = !hit ? '0 :
                      (row_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : row_ext[OUT_W-1:0];
    res.match_col   = !hit ? '0 :
                      (col_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : col_ext[OUT_W-1:0];
    res.match_total = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      row_r  <= POS_WIDTH'(1);
      col_r  <= POS_WIDTH'(1);
      cnt_r  <= '0;
    end else if (fire) begin
      fill_r <= fill_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Window contents beyond the fill count are never compared, so they
  // need no reset and no clearing at the start of a file.
  always_ff @(posedge clk) begin
    if (fire && keep) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_chr_r[j] <= win_chr_nxt[j];
        win_row_r[j] <= win_row_nxt[j];
        win_col_r[j] <= win_col_nxt[j];
      end
    end
  end

endmodule

// ----- hdl/whitespace_blind_pattern_matcher_top.sv -----
// ----------------------------------------------------------------------------
// Whitespace-blind pattern matcher, top level
// Takes one text byte per beat and returns one result beat per byte. Letters
// are folded to lower case; space and tab are skipped for the compare but
// advance the column, and newline is skipped, advances the row and restarts
// the column. A match against a pattern of 1 to MAX_PATTERN bytes reports the
// row and column of its first character and a saturating match count; matches
// may overlap. The block takes one byte every clock cycle unless out_ready
// holds the output. An accepted beat waits in the input register, then the
// window compare and position update run in a single pass into the result
// register. Program the pattern only while no byte is in flight.
// ----------------------------------------------------------------------------
module whitespace_blind_pattern_matcher_top #(
  parameter int MAX_PATTERN = wbpm_pkg::MAX_PATTERN_DEF,
  parameter int POS_WIDTH   = wbpm_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wbpm_pkg::DATA_W-1:0]  in_data_byte,
  input  logic                         in_start_of_file,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_match_found,
  output logic [wbpm_pkg::OUT_W-1:0]   out_match_row,
  output logic [wbpm_pkg::OUT_W-1:0]   out_match_col,
  output logic [wbpm_pkg::OUT_W-1:0]   out_match_total,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wbpm_pkg::PDATA_W-1:0] pwdata,
  output logic [wbpm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import wbpm_pkg::*;

  logic              in_v_r;
  logic [DATA_W-1:0] data_r;
  logic              sof_r;
  logic              out_v_r;
  res_t              res_r;
  res_t              res;
  logic              fire;
  logic [PAT_W-1:0]  pattern_chars;
  logic [LEN_W-1:0]  pattern_length;

  // A held beat moves into the result register when that register is empty
  // or being drained in the same cycle.
  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;
  assign pready   = 1'b1;

  wbpm_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pattern_chars  (pattern_chars),
    .pattern_length (pattern_length)
  );

  wbpm_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .POS_WIDTH   (POS_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .data_byte      (data_r),
    .start_of_file  (sof_r),
    .pattern_chars  (pattern_chars),
    .pattern_length (pattern_length),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      sof_r  <= in_start_of_file;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_match_found = res_r.match_found;
  assign out_match_row   = res_r.match_row;
  assign out_match_col   = res_r.match_col;
  assign out_match_total = res_r.match_total;

endmodule
